### rtl/core/impq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impq_pkg
// Shared types and constants of the indexed min-priority queue unit.
// ----------------------------------------------------------------------------
package impq_pkg;

  localparam int NODE_COUNT_DEFAULT = 1024;
  localparam int KEY_BITS_DEFAULT   = 31;

  // Fixed payload widths of the channels
  localparam int NODE_ID_BITS   = 10;
  localparam int KEY_VALUE_BITS = 31;

  typedef enum logic {
    CMD_SET    = 1'b0,
    CMD_REMOVE = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_CLIMB,
    ST_DONE
  } state_t;

endpackage

### rtl/core/impq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impq_req_if
// Command channel: set a node's key or remove the node.
// ----------------------------------------------------------------------------
interface impq_req_if;
  logic                                valid;
  logic                                ready;
  impq_pkg::command_t                  command;
  logic [impq_pkg::NODE_ID_BITS-1:0]   node_id;
  logic [impq_pkg::KEY_VALUE_BITS-1:0] key_value;

  modport source (output valid, output command, output node_id, output key_value,
                  input ready);
  modport sink   (input valid, input command, input node_id, input key_value,
                  output ready);
endinterface

### rtl/core/impq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impq_rsp_if
// Result channel: current minimum, empty flag and bad-remove flag.
// ----------------------------------------------------------------------------
interface impq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [impq_pkg::NODE_ID_BITS-1:0]   min_node;
  logic [impq_pkg::KEY_VALUE_BITS-1:0] min_key;
  logic                                queue_empty;
  logic                                bad_remove;

  modport source (output valid, output min_node, output min_key, output queue_empty,
                  output bad_remove, input ready);
  modport sink   (input valid, input min_node, input min_key, input queue_empty,
                  input bad_remove, output ready);
endinterface

### rtl/core/indexed_min_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_priority_queue_unit
// Indexed min-priority queue built on a tournament tree held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per beat: set a node's key (insert or update) or
//   remove the node. rsp returns one beat per command with the present node
//   of smallest key (ties to the smaller id), its key, an empty flag and a
//   flag for removing an absent or out-of-range node.
//   The tree RAM holds 2*2^L entries, L = clog2(NODE_COUNT): leaves at
//   2^L + id, winners of each subtree above them, the root at index 1.
//   A command rewrites its leaf and repairs the path to the root, one level
//   per cycle, reading the sibling while writing the parent.
//   Order: a command passes the leaf state, one climb state per level and
//   the done state, where the result loads into the output register; a
//   bad removal leaves from the leaf state and an out-of-range id goes
//   straight to done. One command is in flight at a time; the next one
//   is taken the cycle after the result loads.
//   Reset: a clearing pass writes every RAM entry empty, with req.ready low.
//   Stall: a result waits in the output register; the next command is
//   accepted meanwhile and its result is held until rsp.ready frees the
//   register.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue_unit #(
  parameter int NODE_COUNT = impq_pkg::NODE_COUNT_DEFAULT,
  parameter int KEY_BITS   = impq_pkg::KEY_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  impq_req_if.sink    req,
  impq_rsp_if.source  rsp
);

  localparam int LEVELS      = $clog2(NODE_COUNT);
  localparam int ADDR_BITS   = LEVELS + 1;
  localparam int TREE_DEPTH  = 2 ** ADDR_BITS;
  localparam int ENTRY_BITS  = 1 + KEY_BITS + LEVELS;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [LEVELS-1:0]   id;
  } entry_t;

  impq_pkg::state_t    state, state_next;
  logic [ADDR_BITS-1:0] clr_addr, clr_addr_next;
  logic [ADDR_BITS-1:0] pos, pos_next;
  entry_t               cur, cur_next;
  entry_t               root;
  logic                 bad, bad_next;
  impq_pkg::command_t   cmd;
  logic [LEVELS-1:0]    id_reg;
  logic [KEY_BITS-1:0]  key_reg;

  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  entry_t               wr_entry;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  entry_t               rd_entry;

  logic                 in_fire;
  logic                 in_range;
  logic [LEVELS-1:0]    in_idx;
  logic                 load_out;
  logic                 cur_wins;
  logic [ADDR_BITS-1:0] parent;
  entry_t               new_leaf;

  logic                                out_valid;
  logic [impq_pkg::NODE_ID_BITS-1:0]   out_node;
  logic [impq_pkg::KEY_VALUE_BITS-1:0] out_key;
  logic                                out_empty;
  logic                                out_bad;

  impq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TREE_DEPTH)
  ) u_tree (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  assign in_fire  = req.valid && req.ready;
  assign in_idx   = LEVELS'(req.node_id);
  assign in_range = 32'(req.node_id) < NODE_COUNT;
  assign parent   = pos >> 1;

  // Current path entry beats the sibling: smaller key, then smaller id
  assign cur_wins = cur.valid && (!rd_entry.valid || (cur.key < rd_entry.key) ||
                    ((cur.key == rd_entry.key) && (cur.id < rd_entry.id)));

  always_comb begin
    new_leaf.valid = (cmd == impq_pkg::CMD_SET);
    new_leaf.key   = (cmd == impq_pkg::CMD_SET) ? key_reg : '0;
    new_leaf.id    = id_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= impq_pkg::ST_CLEAR;
      clr_addr <= '0;
      root     <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (wr_en && (wr_addr == ADDR_BITS'(1))) begin
        root <= wr_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    bad <= bad_next;
    if (in_fire) begin
      cmd     <= req.command;
      id_reg  <= in_idx;
      key_reg <= KEY_BITS'(req.key_value);
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    pos_next      = pos;
    cur_next      = cur;
    bad_next      = bad;
    wr_en         = 1'b0;
    wr_addr       = clr_addr;
    wr_entry      = '0;
    rd_addr       = {1'b1, in_idx};
    req.ready     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      impq_pkg::ST_CLEAR: begin
        wr_en         = 1'b1;
        clr_addr_next = clr_addr + ADDR_BITS'(1);
        if (clr_addr == '1) begin
          state_next = impq_pkg::ST_IDLE;
        end
      end
      impq_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          // leaf read is issued this cycle from the request payload
          pos_next = {1'b1, in_idx};
          bad_next = 1'b0;
          if (!in_range) begin
            bad_next   = (req.command == impq_pkg::CMD_REMOVE);
            state_next = impq_pkg::ST_DONE;
          end else begin
            state_next = impq_pkg::ST_LEAF;
          end
        end
      end
      impq_pkg::ST_LEAF: begin
        if ((cmd == impq_pkg::CMD_REMOVE) && !rd_entry.valid) begin
          bad_next   = 1'b1;
          state_next = impq_pkg::ST_DONE;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = pos;
          wr_entry   = new_leaf;
          cur_next   = new_leaf;
          rd_addr    = pos ^ ADDR_BITS'(1);
          state_next = impq_pkg::ST_CLIMB;
        end
      end
      impq_pkg::ST_CLIMB: begin
        // write the parent and fetch its sibling in the same cycle
        wr_en    = 1'b1;
        wr_addr  = parent;
        wr_entry = cur_wins ? cur : rd_entry;
        cur_next = wr_entry;
        pos_next = parent;
        rd_addr  = parent ^ ADDR_BITS'(1);
        if (parent == ADDR_BITS'(1)) begin
          state_next = impq_pkg::ST_DONE;
        end
      end
      impq_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = impq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = impq_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_node  <= root.valid ? impq_pkg::NODE_ID_BITS'(root.id) : '0;
      out_key   <= root.valid ? impq_pkg::KEY_VALUE_BITS'(root.key) : '0;
      out_empty <= !root.valid;
      out_bad   <= bad;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.min_node    = out_node;
  assign rsp.min_key     = out_key;
  assign rsp.queue_empty = out_empty;
  assign rsp.bad_remove  = out_bad;

endmodule

### rtl/core/impq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module impq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
